@@ hdl/assert_macros.svh @@
// Assertion macros used by the resampler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PLAR_ASSERT_HOLD(name, ck, rs, expr, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (expr)) else $error(msg);
`define PLAR_ASSERT_IMPL(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`else
`define PLAR_ASSERT_HOLD(name, ck, rs, expr, msg)
`define PLAR_ASSERT_IMPL(name, ck, rs, ante, cons, msg)
`endif
`endif

@@ hdl/plar_pkg.sv @@
// Types, widths and constants of the polyline arc length resampler.
package plar_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int WIDE_W    = 2 * DIFF_W;
  localparam int DIST_W    = DIFF_W;
  localparam int REM_W     = DIST_W + 2;
  localparam int STEP_W    = 23;
  localparam int LEFT_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W     = 7;

  localparam int MUL_STEPS  = DIFF_W;
  localparam int DIV_STEPS  = WIDE_W;
  localparam int SQRT_STEPS = WIDE_W / 2;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_GAP   = 2'd1;

  localparam logic [STEP_W-1:0] STEP_RESET = 23'd19661;
  localparam logic [STEP_W-1:0] GAP_RESET  = 23'd6554;

  typedef enum logic [1:0] {
    ARITH_MUL,
    ARITH_DIV,
    ARITH_SQRT
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_CHECK,
    ST_MULX,
    ST_DIVX,
    ST_MULY,
    ST_DIVY,
    ST_NDIV,
    ST_PUSH,
    ST_FINISH,
    ST_LAST
  } state_t;

  function automatic logic [DIFF_W-1:0] mag(input logic [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(~v + 1'b1) : v;
  endfunction

endpackage

@@ hdl/plar_in_if.sv @@
// Waypoint channel of the resampler.
interface plar_in_if;
  logic                      valid;
  logic                      ready;
  logic signed [31:0]        waypoint_x;
  logic signed [31:0]        waypoint_y;
  logic                      path_end;

  modport source (output valid, output waypoint_x, output waypoint_y, output path_end,
                  input ready);
  modport sink (input valid, input waypoint_x, input waypoint_y, input path_end,
                output ready);
endinterface

@@ hdl/plar_out_if.sv @@
// Sampled point channel of the resampler.
interface plar_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               final_point;
  logic               samples_truncated;
  logic               path_error;

  modport source (output valid, output point_x, output point_y, output final_point,
                  output samples_truncated, output path_error, input ready);
  modport sink (input valid, input point_x, input point_y, input final_point,
                input samples_truncated, input path_error, output ready);
endinterface

@@ hdl/plar_arith.sv @@
// Bit-serial multiply, restoring divide and integer square root unit.
module plar_arith (
  input  logic                           clk,
  input  logic                           rst,
  input  plar_pkg::arith_ctl_t           ctl,
  input  logic [plar_pkg::WIDE_W-1:0]    opa,
  input  logic [plar_pkg::DIFF_W-1:0]    opb,
  output plar_pkg::arith_sts_t           sts,
  output logic [plar_pkg::WIDE_W-1:0]    result,
  output logic [plar_pkg::DIFF_W-1:0]    remainder
);

  localparam int WW = plar_pkg::WIDE_W;
  localparam int DW = plar_pkg::DIFF_W;
  localparam int RW = DW + 4;

  logic                      busy;
  logic                      done;
  plar_pkg::arith_op_t       op;
  logic [plar_pkg::CNT_W-1:0] cnt;
  logic [WW-1:0]             acc;
  logic [WW-1:0]             sh;
  logic [DW-1:0]             aux;
  logic [RW-1:0]             rm;
  logic [DW-1:0]             root;

  logic [DW:0]   div_trial;
  logic          div_ge;
  logic [RW-1:0] sq_trial;
  logic [RW-1:0] sq_t;
  logic          sq_ge;

  assign div_trial = {rm[DW-1:0], sh[WW-1]};
  assign div_ge    = div_trial >= {1'b0, aux};
  assign sq_trial  = {rm[RW-3:0], sh[WW-1:WW-2]};
  assign sq_t      = {2'b00, root, 2'b01};
  assign sq_ge     = sq_trial >= sq_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start && !busy) begin
      op   <= ctl.op;
      sh   <= opa;
      aux  <= opb;
      acc  <= '0;
      rm   <= '0;
      root <= '0;
      unique case (ctl.op)
        plar_pkg::ARITH_MUL:  cnt <= plar_pkg::CNT_W'(plar_pkg::MUL_STEPS - 1);
        plar_pkg::ARITH_DIV:  cnt <= plar_pkg::CNT_W'(plar_pkg::DIV_STEPS - 1);
        plar_pkg::ARITH_SQRT: cnt <= plar_pkg::CNT_W'(plar_pkg::SQRT_STEPS - 1);
        default:              cnt <= '0;
      endcase
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      unique case (op)
        plar_pkg::ARITH_MUL: begin
          if (aux[0]) begin
            acc <= acc + sh;
          end
          sh  <= {sh[WW-2:0], 1'b0};
          aux <= {1'b0, aux[DW-1:1]};
        end
        plar_pkg::ARITH_DIV: begin
          if (div_ge) begin
            rm <= RW'(div_trial - {1'b0, aux});
          end else begin
            rm <= RW'(div_trial);
          end
          sh <= {sh[WW-2:0], div_ge};
        end
        plar_pkg::ARITH_SQRT: begin
          if (sq_ge) begin
            rm <= sq_trial - sq_t;
          end else begin
            rm <= sq_trial;
          end
          root <= {root[DW-2:0], sq_ge};
          sh   <= {sh[WW-3:0], 2'b00};
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (op)
      plar_pkg::ARITH_MUL: result = acc;
      plar_pkg::ARITH_DIV: result = sh;
      default:             result = WW'(root);
    endcase
  end

  assign remainder = rm[DW-1:0];
  assign sts.busy  = busy;
  assign sts.done  = done;

endmodule

@@ hdl/polyline_arc_length_resampler.sv @@
// Top level of the polyline arc length resampler with its sequencer and datapath.
// Throughput is one waypoint at a time, set by the shared bit-serial arithmetic unit.
// The output register lets the next waypoint in while the last point waits.
// Reset (rst, synchronous) clears all path state and loads the default registers.
`include "assert_macros.svh"
module polyline_arc_length_resampler #(
  parameter int MAX_STEPS = 61
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [plar_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [plar_pkg::STEP_W-1:0]      cfg_data,
  plar_in_if.sink                          waypoint,
  plar_out_if.source                       point
);

  localparam int CW  = plar_pkg::COORD_W;
  localparam int DW  = plar_pkg::DIFF_W;
  localparam int WW  = plar_pkg::WIDE_W;
  localparam int SW  = plar_pkg::STEP_W;
  localparam int LW  = plar_pkg::LEFT_W;
  localparam int RMW = plar_pkg::REM_W;
  localparam int J_W = $clog2(MAX_STEPS + 1);
  localparam int MJW = SW + J_W;

  plar_pkg::state_t     state;
  plar_pkg::state_t     state_next;
  plar_pkg::arith_ctl_t ctl;
  plar_pkg::arith_sts_t sts;
  logic [WW-1:0]        opa;
  logic [DW-1:0]        opb;
  logic [WW-1:0]        result;
  logic [DW-1:0]        remainder;

  logic [SW-1:0] sample_step;
  logic [SW-1:0] short_gap;

  logic                 launched;
  logic                 have_prev;
  logic                 first_pushed;
  logic                 held_valid;
  logic [1:0]           pushed_count;
  logic [LW-1:0]        leftover;
  logic                 phase;
  logic                 sampling;
  logic                 trunc;
  logic [J_W-1:0]       j;
  logic                 out_valid;

  logic signed [CW-1:0] prev_x;
  logic signed [CW-1:0] prev_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic                 end_f;
  logic signed [CW-1:0] base_x;
  logic signed [CW-1:0] base_y;
  logic signed [CW-1:0] pt_x;
  logic signed [CW-1:0] pt_y;
  logic signed [CW-1:0] held_x;
  logic signed [CW-1:0] held_y;
  logic [WW-1:0]        sqsum;
  logic [WW-1:0]        prod;
  logic [DW-1:0]        dist_d;
  logic [DW-1:0]        dist_n;
  logic [J_W-1:0]       ncap;
  logic [MJW-1:0]       mulj;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic                 out_fin;
  logic                 out_trunc;
  logic                 out_err;

  logic                 in_take;
  logic                 slot_free;
  logic [SW-1:0]        step_eff;
  logic [SW-1:0]        need;
  logic [DW-1:0]        ex_d;
  logic [DW-1:0]        ey_d;
  logic [DW-1:0]        ex_mag;
  logic [DW-1:0]        ey_mag;
  logic [DW-1:0]        mul_sel;
  logic [DW-1:0]        div_sel;
  logic [DW-1:0]        quot;
  logic                 d_short;
  logic                 dn_short;
  logic                 drop;
  logic                 push_go;
  logic [DW:0]          left_sum;
  logic [RMW-1:0]       rem_raw;
  logic [DW-1:0]        n_q;
  logic signed [CW-1:0] new_x;
  logic signed [CW-1:0] new_y;
  logic                 emit_load;
  logic signed [CW-1:0] emit_x;
  logic signed [CW-1:0] emit_y;
  logic                 emit_fin;
  logic                 emit_err;

  function automatic logic signed [CW-1:0] apply_ofs(input logic signed [CW-1:0] base,
                                                     input logic neg,
                                                     input logic [DW-1:0] q);
    logic [DW:0] sum;
    sum = {{2{base[CW-1]}}, base} + (neg ? (DW+1)'(~{1'b0, q} + 1'b1) : {1'b0, q});
    return sum[CW-1:0];
  endfunction

  plar_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .opa       (opa),
    .opb       (opb),
    .sts       (sts),
    .result    (result),
    .remainder (remainder)
  );

  assign in_take   = waypoint.valid && waypoint.ready;
  assign slot_free = !out_valid || point.ready;
  assign step_eff  = (sample_step == '0) ? SW'(1) : sample_step;
  assign need      = ({9'd0, step_eff} > leftover) ? SW'({9'd0, step_eff} - leftover) : '0;
  assign ex_d      = {end_x[CW-1], end_x} - {base_x[CW-1], base_x};
  assign ey_d      = {end_y[CW-1], end_y} - {base_y[CW-1], base_y};
  assign ex_mag    = plar_pkg::mag(ex_d);
  assign ey_mag    = plar_pkg::mag(ey_d);
  assign mul_sel   = sampling ? DW'(mulj) : DW'(need);
  assign div_sel   = sampling ? dist_n : dist_d;
  assign quot      = (div_sel == '0) ? '0 : result[DW-1:0];
  assign d_short   = dist_d < DW'(need);
  assign dn_short  = dist_n < DW'(short_gap);
  assign drop      = (leftover < {10'd0, step_eff[SW-1:1]}) && pushed_count == 2'd2;
  assign push_go   = !held_valid || slot_free;
  assign left_sum  = {2'b00, leftover} + {1'b0, dist_d};
  assign n_q       = result[DW-1:0];
  assign rem_raw   = {2'b00, dist_d} - RMW'(need) - {2'b00, dist_n} + RMW'(remainder);
  assign new_x     = apply_ofs(base_x, ex_d[DW-1], quot);
  assign new_y     = apply_ofs(base_y, ey_d[DW-1], quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_step <= plar_pkg::STEP_RESET;
      short_gap   <= plar_pkg::GAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        plar_pkg::REG_SAMPLE_STEP: sample_step <= cfg_data;
        plar_pkg::REG_SHORT_GAP:   short_gap   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      plar_pkg::ST_IDLE: begin
        if (in_take) begin
          if (!have_prev) begin
            state_next = waypoint.path_end ? plar_pkg::ST_ERR : plar_pkg::ST_IDLE;
          end else begin
            state_next = plar_pkg::ST_SQX;
          end
        end
      end
      plar_pkg::ST_SQX:   if (sts.done) state_next = plar_pkg::ST_SQY;
      plar_pkg::ST_SQY:   if (sts.done) state_next = plar_pkg::ST_ROOT;
      plar_pkg::ST_ROOT: begin
        if (sts.done) begin
          state_next = phase ? plar_pkg::ST_NDIV : plar_pkg::ST_CHECK;
        end
      end
      plar_pkg::ST_CHECK: state_next = d_short ? plar_pkg::ST_FINISH : plar_pkg::ST_MULX;
      plar_pkg::ST_MULX:  if (sts.done) state_next = plar_pkg::ST_DIVX;
      plar_pkg::ST_DIVX:  if (sts.done) state_next = plar_pkg::ST_MULY;
      plar_pkg::ST_MULY:  if (sts.done) state_next = plar_pkg::ST_DIVY;
      plar_pkg::ST_DIVY: begin
        if (sts.done) begin
          state_next = sampling ? plar_pkg::ST_PUSH : plar_pkg::ST_SQX;
        end
      end
      plar_pkg::ST_NDIV: begin
        if (sts.done) begin
          state_next = dn_short ? plar_pkg::ST_PUSH : plar_pkg::ST_MULX;
        end
      end
      plar_pkg::ST_PUSH: begin
        if (push_go) begin
          state_next = (sampling && j != ncap) ? plar_pkg::ST_MULX : plar_pkg::ST_FINISH;
        end
      end
      plar_pkg::ST_FINISH: begin
        if (!end_f) begin
          state_next = plar_pkg::ST_IDLE;
        end else if (drop || !held_valid || slot_free) begin
          state_next = plar_pkg::ST_LAST;
        end
      end
      plar_pkg::ST_LAST:  if (slot_free) state_next = plar_pkg::ST_IDLE;
      plar_pkg::ST_ERR:   if (slot_free) state_next = plar_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.start = 1'b0;
    ctl.op    = plar_pkg::ARITH_MUL;
    opa       = '0;
    opb       = '0;
    emit_load = 1'b0;
    emit_x    = held_x;
    emit_y    = held_y;
    emit_fin  = 1'b0;
    emit_err  = 1'b0;
    unique case (state)
      plar_pkg::ST_IDLE, plar_pkg::ST_CHECK: begin
      end
      plar_pkg::ST_SQX: begin
        ctl.start = !launched;
        opa       = WW'(ex_mag);
        opb       = ex_mag;
      end
      plar_pkg::ST_SQY: begin
        ctl.start = !launched;
        opa       = WW'(ey_mag);
        opb       = ey_mag;
      end
      plar_pkg::ST_ROOT: begin
        ctl.start = !launched;
        ctl.op    = plar_pkg::ARITH_SQRT;
        opa       = sqsum;
      end
      plar_pkg::ST_MULX: begin
        ctl.start = !launched;
        opa       = WW'(ex_mag);
        opb       = mul_sel;
      end
      plar_pkg::ST_MULY: begin
        ctl.start = !launched;
        opa       = WW'(ey_mag);
        opb       = mul_sel;
      end
      plar_pkg::ST_DIVX, plar_pkg::ST_DIVY: begin
        ctl.start = !launched;
        ctl.op    = plar_pkg::ARITH_DIV;
        opa       = prod;
        opb       = div_sel;
      end
      plar_pkg::ST_NDIV: begin
        ctl.start = !launched;
        ctl.op    = plar_pkg::ARITH_DIV;
        opa       = WW'(dist_n);
        opb       = DW'(step_eff);
      end
      plar_pkg::ST_PUSH:   emit_load = held_valid && slot_free;
      plar_pkg::ST_FINISH: emit_load = end_f && !drop && held_valid && slot_free;
      plar_pkg::ST_LAST: begin
        emit_load = slot_free;
        emit_x    = end_x;
        emit_y    = end_y;
        emit_fin  = 1'b1;
      end
      plar_pkg::ST_ERR: begin
        emit_load = slot_free;
        emit_x    = '0;
        emit_y    = '0;
        emit_fin  = 1'b1;
        emit_err  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= plar_pkg::ST_IDLE;
      launched     <= 1'b0;
      have_prev    <= 1'b0;
      first_pushed <= 1'b0;
      held_valid   <= 1'b0;
      pushed_count <= '0;
      leftover     <= '0;
      phase        <= 1'b0;
      sampling     <= 1'b0;
      trunc        <= 1'b0;
      j            <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.start) begin
        launched <= 1'b1;
      end else if (sts.done) begin
        launched <= 1'b0;
      end
      if (emit_load) begin
        out_valid <= 1'b1;
      end else if (point.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        plar_pkg::ST_IDLE: begin
          if (in_take) begin
            trunc    <= 1'b0;
            phase    <= 1'b0;
            sampling <= 1'b0;
            if (!have_prev && !waypoint.path_end) begin
              have_prev <= 1'b1;
            end
          end
        end
        plar_pkg::ST_ROOT: begin
          if (sts.done && !phase && !first_pushed) begin
            first_pushed <= 1'b1;
            held_valid   <= 1'b1;
            pushed_count <= 2'd1;
          end
        end
        plar_pkg::ST_CHECK: begin
          if (d_short) begin
            leftover <= (left_sum[DW:LW] != '0) ? '1 : left_sum[LW-1:0];
          end
        end
        plar_pkg::ST_DIVY: begin
          if (sts.done && !sampling) begin
            phase <= 1'b1;
          end
        end
        plar_pkg::ST_NDIV: begin
          if (sts.done) begin
            if (rem_raw[RMW-1]) begin
              leftover <= '0;
            end else if (rem_raw[RMW-2:LW] != '0) begin
              leftover <= '1;
            end else begin
              leftover <= rem_raw[LW-1:0];
            end
            trunc    <= !dn_short && (n_q > DW'(MAX_STEPS));
            sampling <= !dn_short;
            j        <= '0;
          end
        end
        plar_pkg::ST_PUSH: begin
          if (push_go) begin
            held_valid <= 1'b1;
            if (pushed_count != 2'd2) begin
              pushed_count <= pushed_count + 1'b1;
            end
            if (sampling && j != ncap) begin
              j <= j + 1'b1;
            end
          end
        end
        plar_pkg::ST_FINISH: begin
          if (end_f && (drop || slot_free)) begin
            held_valid <= 1'b0;
          end
        end
        plar_pkg::ST_LAST, plar_pkg::ST_ERR: begin
          if (slot_free) begin
            have_prev    <= 1'b0;
            first_pushed <= 1'b0;
            held_valid   <= 1'b0;
            pushed_count <= '0;
            leftover     <= '0;
          end
        end
        plar_pkg::ST_SQX, plar_pkg::ST_SQY, plar_pkg::ST_MULX, plar_pkg::ST_DIVX,
        plar_pkg::ST_MULY: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_x     <= emit_x;
      out_y     <= emit_y;
      out_fin   <= emit_fin;
      out_err   <= emit_err;
      out_trunc <= trunc && !emit_err;
    end
    case (state)
      plar_pkg::ST_IDLE: begin
        if (in_take) begin
          end_x <= waypoint.waypoint_x;
          end_y <= waypoint.waypoint_y;
          end_f <= waypoint.path_end;
          if (!have_prev) begin
            prev_x <= waypoint.waypoint_x;
            prev_y <= waypoint.waypoint_y;
          end else begin
            base_x <= prev_x;
            base_y <= prev_y;
          end
        end
      end
      plar_pkg::ST_SQX:  if (sts.done) sqsum <= result;
      plar_pkg::ST_SQY:  if (sts.done) sqsum <= sqsum + result;
      plar_pkg::ST_ROOT: begin
        if (sts.done) begin
          if (phase) begin
            dist_n <= result[DW-1:0];
          end else begin
            dist_d <= result[DW-1:0];
            if (!first_pushed) begin
              held_x <= prev_x;
              held_y <= prev_y;
            end
          end
        end
      end
      plar_pkg::ST_MULX, plar_pkg::ST_MULY: if (sts.done) prod <= result;
      plar_pkg::ST_DIVX: if (sts.done) pt_x <= new_x;
      plar_pkg::ST_DIVY: begin
        if (sts.done) begin
          pt_y <= new_y;
          if (!sampling) begin
            base_x <= pt_x;
            base_y <= new_y;
          end
        end
      end
      plar_pkg::ST_NDIV: begin
        if (sts.done) begin
          ncap <= (n_q > DW'(MAX_STEPS)) ? J_W'(MAX_STEPS) : n_q[J_W-1:0];
          mulj <= '0;
        end
      end
      plar_pkg::ST_PUSH: begin
        if (push_go) begin
          held_x <= pt_x;
          held_y <= pt_y;
          mulj   <= mulj + MJW'(step_eff);
        end
      end
      plar_pkg::ST_FINISH: begin
        if (!end_f) begin
          prev_x <= end_x;
          prev_y <= end_y;
        end
      end
      default: begin
      end
    endcase
  end

  assign waypoint.ready          = state == plar_pkg::ST_IDLE;
  assign point.valid             = out_valid;
  assign point.point_x           = out_x;
  assign point.point_y           = out_y;
  assign point.final_point       = out_fin;
  assign point.samples_truncated = out_trunc;
  assign point.path_error        = out_err;

  `PLAR_ASSERT_HOLD(a_start_free, clk, rst, !(ctl.start && sts.busy), "Unit started busy.")
  `PLAR_ASSERT_IMPL(a_held_first, clk, rst, !first_pushed, !held_valid, "Early held point.")
  `PLAR_ASSERT_IMPL(a_err_final, clk, rst, out_valid && out_err, out_fin, "Error not final.")
  `PLAR_ASSERT_HOLD(a_count_sat, clk, rst, pushed_count != 2'd3, "Push count overflow.")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the polyline arc length resampler with a built-in path predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int MAX_STEPS = 61;
  localparam int SETTLE = 2000;
  localparam int HOLD_CYCLES = 3000;
  localparam int PHASE_ITEMS = 20;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam logic [1:0] IDX_UNUSED_LO = 2'd2;
  localparam logic [1:0] IDX_UNUSED_HI = 2'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               fin;
    logic               trunc;
    logic               err;
  } point_t;

  typedef enum logic [1:0] {
    ROW_WAYPOINT,
    ROW_CONFIG
  } row_kind_t;

  typedef struct {
    row_kind_t      kind;
    logic [31:0]    x;
    logic [31:0]    y;
    logic           last;
    logic [1:0]     index;
    logic [22:0]    data;
    bit             typed;
    point_t         want;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [plar_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [plar_pkg::STEP_W-1:0] cfg_data;

  plar_in_if wp_if ();
  plar_out_if pt_if ();

  polyline_arc_length_resampler dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .waypoint(wp_if), .point(pt_if)
  );

  // Predictor state.
  logic [22:0] step_reg;
  logic [22:0] gap_reg;
  longint prev_x, prev_y, held_x, held_y;
  bit have_prev, first_pushed, held_valid;
  logic [31:0] leftover;
  int pushed_count;
  point_t call_points[$];
  point_t expected_points[$];

  int mismatches;
  longint cycles;
  int burst_left;
  bit hold_req;
  int accepted;
  row_t rows[$];

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned seg_len(longint ax, longint ay, longint bx, longint by);
    logic [33:0] mx, my;
    logic [69:0] sq, t2;
    logic [34:0] r, t;
    mx = 34'(magn(bx - ax));
    my = 34'(magn(by - ay));
    sq = 70'(mx) * 70'(mx) + 70'(my) * 70'(my);
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      t = r | (35'd1 << b);
      t2 = 70'(t) * 70'(t);
      if (t2 <= sq) r = t;
    end
    return longint'(r);
  endfunction

  function automatic longint scaled(longint diff, longint unsigned mul, longint unsigned dv);
    longint unsigned q;
    if (dv == 0) return 0;
    q = magn(diff) * mul / dv;
    return diff < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic void add_point(longint x, longint y, logic fin, logic err);
    point_t p;
    p.x = x[31:0];
    p.y = y[31:0];
    p.fin = fin;
    p.trunc = 1'b0;
    p.err = err;
    call_points = {call_points, p};
  endfunction

  function automatic void push_sample(longint x, longint y);
    if (held_valid) add_point(held_x, held_y, 1'b0, 1'b0);
    held_x = x;
    held_y = y;
    held_valid = 1;
    if (pushed_count < 2) pushed_count++;
  endfunction

  function automatic void clear_path();
    prev_x = 0;
    prev_y = 0;
    have_prev = 0;
    first_pushed = 0;
    leftover = '0;
    held_x = 0;
    held_y = 0;
    held_valid = 0;
    pushed_count = 0;
  endfunction

  function automatic void resample_waypoint(logic signed [31:0] wx, logic signed [31:0] wy,
                                            logic last);
    longint x, y, sx, sy, rem;
    longint unsigned stp, d, need, dn, n, s;
    bit tr;
    x = wx;
    y = wy;
    stp = (step_reg != 0) ? longint'(step_reg) : 1;
    tr = 0;
    call_points.delete();
    if (!have_prev) begin
      if (last) begin
        add_point(0, 0, 1'b1, 1'b1);
        clear_path();
      end else begin
        prev_x = x;
        prev_y = y;
        have_prev = 1;
      end
    end else begin
      d = seg_len(prev_x, prev_y, x, y);
      need = (stp > leftover) ? stp - leftover : 0;
      if (!first_pushed) begin
        push_sample(prev_x, prev_y);
        first_pushed = 1;
      end
      if (d < need) begin
        s = longint'(leftover) + d;
        leftover = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      end else begin
        sx = prev_x + scaled(x - prev_x, need, d);
        sy = prev_y + scaled(y - prev_y, need, d);
        dn = seg_len(sx, sy, x, y);
        n = dn / stp;
        rem = longint'(d - need) - longint'(n * stp);
        if (rem < 0) rem = 0;
        if (rem > 64'hFFFF_FFFF) rem = 64'hFFFF_FFFF;
        if (dn < gap_reg) begin
          push_sample(sx, sy);
        end else begin
          if (n > MAX_STEPS) begin
            n = MAX_STEPS;
            tr = 1;
          end
          for (longint unsigned j = 0; j <= n; j++)
            push_sample(sx + scaled(x - sx, stp * j, dn), sy + scaled(y - sy, stp * j, dn));
        end
        leftover = rem[31:0];
      end
      prev_x = x;
      prev_y = y;
      if (last) begin
        if (leftover < (stp >> 1) && pushed_count >= 2) held_valid = 0;
        else if (held_valid) add_point(held_x, held_y, 1'b0, 1'b0);
        add_point(x, y, 1'b1, 1'b0);
        clear_path();
      end
    end
    foreach (call_points[k]) begin
      call_points[k].trunc = tr;
      expected_points = {expected_points, call_points[k]};
    end
  endfunction

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[polyline_arc_length_resampler] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (!rst && pt_if.valid && pt_if.ready) begin
      if (expected_points.size() == 0) begin
        report($sformatf("unexpected point x=%0d y=%0d", pt_if.point_x, pt_if.point_y));
      end else begin
        want = expected_points.pop_front();
        if (pt_if.point_x !== want.x)
          report($sformatf("point_x %0d, expected %0d", pt_if.point_x, want.x));
        if (pt_if.point_y !== want.y)
          report($sformatf("point_y %0d, expected %0d", pt_if.point_y, want.y));
        if (pt_if.final_point !== want.fin)
          report($sformatf("final_point %b, expected %b", pt_if.final_point, want.fin));
        if (pt_if.samples_truncated !== want.trunc)
          report($sformatf("samples_truncated %b, expected %b",
                           pt_if.samples_truncated, want.trunc));
        if (pt_if.path_error !== want.err)
          report($sformatf("path_error %b, expected %b", pt_if.path_error, want.err));
      end
    end
  end

  initial begin
    int mode, mode_left;
    mode = 0;
    mode_left = 0;
    pt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pt_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0: pt_if.ready = 1'b1;
          1: pt_if.ready = ($urandom_range(0, 1) == 1);
          default: pt_if.ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_waypoint(logic [31:0] x, logic [31:0] y, logic last,
                               bit typed = 0, point_t want = '0);
    wp_if.valid = 1'b1;
    wp_if.waypoint_x = x;
    wp_if.waypoint_y = y;
    wp_if.path_end = last;
    @(posedge clk);
    while (!wp_if.ready) @(posedge clk);
    resample_waypoint(x, y, last);
    if (typed) begin
      void'(expected_points.pop_back());
      expected_points = {expected_points, want};
    end
    accepted++;
    @(negedge clk);
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      wp_if.valid = 1'b0;
      repeat ($urandom_range(0, 30)) @(negedge clk);
    end
    burst_left--;
  endtask

  task automatic drain();
    wp_if.valid = 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [22:0] data);
    drain();
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(negedge clk);
    cfg_write = 1'b0;
    if (index == plar_pkg::REG_SAMPLE_STEP) step_reg = data;
    else if (index == plar_pkg::REG_SHORT_GAP) gap_reg = data;
  endtask

  function automatic void add_wp(logic [31:0] x, logic [31:0] y, logic last);
    row_t r;
    r = '{kind: ROW_WAYPOINT, x: x, y: y, last: last, index: '0, data: '0,
          typed: 0, want: '0};
    rows = {rows, r};
  endfunction

  function automatic void add_cfg(logic [1:0] index, logic [22:0] data);
    row_t r;
    r = '{kind: ROW_CONFIG, x: '0, y: '0, last: 1'b0, index: index, data: data,
          typed: 0, want: '0};
    rows = {rows, r};
  endfunction

  task automatic random_path(int span);
    int n_wp;
    logic [31:0] x, y;
    n_wp = ($urandom_range(0, 14) == 0) ? 1 : $urandom_range(2, 6);
    if ($urandom_range(0, 3) == 0) begin
      x = $urandom;
      y = $urandom;
    end else begin
      x = $urandom_range(0, 1310720) - 655360;
      y = $urandom_range(0, 1310720) - 655360;
    end
    for (int i = 0; i < n_wp; i++) begin
      send_waypoint(x, y, i == n_wp - 1);
      if ($urandom_range(0, 11) == 0) begin
        x = $urandom;
        y = $urandom;
      end else begin
        x = x + $urandom_range(0, 2 * span) - span;
        y = y + $urandom_range(0, 2 * span) - span;
      end
    end
  endtask

  initial begin
    row_t r;
    int phase_step;
    logic [22:0] new_step;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    wp_if.valid = 1'b0;
    wp_if.waypoint_x = '0;
    wp_if.waypoint_y = '0;
    wp_if.path_end = 1'b0;
    hold_req = 0;
    mismatches = 0;
    cycles = 0;
    burst_left = 0;
    accepted = 0;
    step_reg = plar_pkg::STEP_RESET;
    gap_reg = plar_pkg::GAP_RESET;
    clear_path();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A path of one waypoint reports an error with a zero point.
    add_wp(32'd0, 32'd0, 1'b1);
    rows[$].typed = 1;
    rows[$].want = '{x: '0, y: '0, fin: 1'b1, trunc: 1'b0, err: 1'b1};
    add_wp(32'd0, 32'd0, 1'b0);
    add_wp(32'd0, 32'd0, 1'b1);
    add_wp(32'd0, 32'd0, 1'b0);
    add_wp(32'd196608, 32'd0, 1'b0);
    add_wp(32'd196608, 32'd131072, 1'b1);
    add_wp(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_wp(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    add_cfg(plar_pkg::REG_SHORT_GAP, 23'd6553600);
    add_wp(32'd0, 32'd0, 1'b0);
    add_wp(32'd655360, 32'd0, 1'b1);
    add_cfg(plar_pkg::REG_SHORT_GAP, 23'd0);
    add_cfg(plar_pkg::REG_SAMPLE_STEP, 23'd6553600);
    add_wp(32'd0, 32'd0, 1'b0);
    add_wp(32'd65536, 32'd0, 1'b0);
    // Shrinking the step mid-path leaves the leftover above the new step.
    add_cfg(plar_pkg::REG_SAMPLE_STEP, 23'd655);
    add_wp(32'd65536, 32'd0, 1'b0);
    add_wp(32'd65536, 32'd65536, 1'b1);
    add_cfg(plar_pkg::REG_SAMPLE_STEP, 23'd0);
    add_wp(32'd0, 32'd0, 1'b0);
    add_wp(32'd100, 32'd0, 1'b1);
    add_cfg(IDX_UNUSED_LO, 23'h7FFFFF);
    add_cfg(IDX_UNUSED_HI, 23'h7FFFFF);
    add_cfg(plar_pkg::REG_SAMPLE_STEP, 23'h7FFFFF);
    add_cfg(plar_pkg::REG_SAMPLE_STEP, plar_pkg::STEP_RESET);
    add_cfg(plar_pkg::REG_SHORT_GAP, plar_pkg::GAP_RESET);
    add_wp(32'hFFFF_0000, 32'h0001_0000, 1'b0);
    add_wp(32'h0000_8000, 32'hFFFF_8000, 1'b1);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.kind == ROW_CONFIG) write_reg(r.index, r.data);
      else send_waypoint(r.x, r.y, r.last, r.typed, r.want);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: new_step = 23'd655;
        1: new_step = 23'($urandom_range(655, 6553600));
        2: new_step = 23'd6553600;
        default: new_step = plar_pkg::STEP_RESET;
      endcase
      write_reg(plar_pkg::REG_SAMPLE_STEP, new_step);
      write_reg(plar_pkg::REG_SHORT_GAP,
                (phase == 2) ? 23'd6553600 : 23'($urandom_range(0, 131072)));
      phase_step = new_step;
      if (phase == 1) hold_req = 1;
      accepted = 0;
      while (accepted < PHASE_ITEMS) random_path(phase_step * 4);
    end

    wp_if.valid = 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("[polyline_arc_length_resampler] OK");
    end else begin
      $display("[polyline_arc_length_resampler] ERROR");
    end
    $finish;
  end

endmodule
